// ===== hw/rtl/lec_pkg.sv =====
// Shared types, constants and codes for the line ending classifier.
`default_nettype none

package lec_pkg;

    // Default sizing handed to the top level parameters
    localparam int ROW_BYTES_DEF  = 16;
    localparam int COUNT_BITS_DEF = 32;

    // Field widths of the beats
    localparam int BYTE_W   = 8;
    localparam int OUT_W    = 32;
    localparam int KIND_W   = 3;
    localparam int LIMIT_W  = 16;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    // Characters of interest
    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPLIT_ON_LINES = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LIMIT      = 8'd1;

    // Line ending classes
    typedef enum logic [KIND_W-1:0] {
        KIND_NONE  = 3'd0,
        KIND_LF    = 3'd1,
        KIND_CR    = 3'd2,
        KIND_CRLF  = 3'd3,
        KIND_MIXED = 3'd4
    } t_kind;

    // Configuration state
    typedef struct packed {
        logic               split_on_lines;
        logic [LIMIT_W-1:0] row_limit;
    } t_cfg;

    // One result beat
    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        logic              row_start;
        logic [OUT_W-1:0]  row_offset;
        logic [OUT_W-1:0]  line_total;
        logic [KIND_W-1:0] ending_kind;
        logic              stop;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/lec_if.sv =====
// Handshake channel interfaces: byte input, result output, configuration write.
`default_nettype none

interface lec_byte_if;
    logic                       valid;
    logic                       ready;
    logic [lec_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface lec_res_if;
    logic                       valid;
    logic                       ready;
    logic [lec_pkg::BYTE_W-1:0] byte_out;
    logic                       row_start;
    logic [lec_pkg::OUT_W-1:0]  row_offset;
    logic [lec_pkg::OUT_W-1:0]  line_total;
    logic [lec_pkg::KIND_W-1:0] ending_kind;
    logic                       stop;

    modport source (output valid, output byte_out, output row_start, output row_offset,
                    output line_total, output ending_kind, output stop, input ready);
    modport sink   (input valid, input byte_out, input row_start, input row_offset,
                    input line_total, input ending_kind, input stop, output ready);
endinterface

interface lec_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lec_pkg::CFG_IDX_W-1:0] index;
    logic [lec_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lec_track.sv =====
// Per-byte tracker: CR pending, line and byte counters, ending class, row starts, stop.
`default_nettype none

module lec_track #(
    parameter int ROW_BYTES  = lec_pkg::ROW_BYTES_DEF,
    parameter int COUNT_BITS = lec_pkg::COUNT_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire logic [lec_pkg::BYTE_W-1:0] i_byte,
    input  wire lec_pkg::t_cfg              i_cfg,
    output lec_pkg::t_result                o_result
);

    localparam int RP_W  = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
    localparam int CMP_W = (COUNT_BITS > lec_pkg::LIMIT_W) ? COUNT_BITS : lec_pkg::LIMIT_W;
    localparam int EXT_W = (COUNT_BITS > lec_pkg::OUT_W) ? COUNT_BITS : lec_pkg::OUT_W;
    localparam logic [RP_W-1:0] ROW_LAST = RP_W'(ROW_BYTES - 1);

    logic                  r_cr_pending, n_cr_pending;
    lec_pkg::t_kind        r_ending, n_ending;
    logic                  r_line_seen;
    logic [COUNT_BITS-1:0] r_byte_count, n_byte_count;
    logic [COUNT_BITS-1:0] r_line_count, n_line_count;
    logic [COUNT_BITS-1:0] r_row_count, n_row_count;
    logic [RP_W-1:0]       r_row_pos, n_row_pos;
    logic                  r_stopped, n_stopped;

    logic                  is_lf;
    logic                  line_event;
    lec_pkg::t_kind        event_kind;
    logic                  row_start;
    logic                  limit_hit;
    logic [EXT_W-1:0]      offset_ext;
    logic [EXT_W-1:0]      line_ext;

    // Line event detection and its class
    always_comb begin
        is_lf      = (i_byte == lec_pkg::CH_LF);
        line_event = is_lf || r_cr_pending;
        if (is_lf) begin
            event_kind = r_cr_pending ? lec_pkg::KIND_CRLF : lec_pkg::KIND_LF;
        end else begin
            event_kind = lec_pkg::KIND_CR;
        end
    end

    // Ending class: first kind wins, any different kind later makes it mixed
    always_comb begin
        n_ending = r_ending;
        if (line_event) begin
            if (r_ending == lec_pkg::KIND_NONE) begin
                n_ending = event_kind;
            end else if (r_ending != event_kind) begin
                n_ending = lec_pkg::KIND_MIXED;
            end
        end
    end

    // A CR always becomes the new pending CR; anything else clears it
    assign n_cr_pending = (i_byte == lec_pkg::CH_CR);

    // Row start before this byte
    always_comb begin
        if (i_cfg.split_on_lines) begin
            row_start = (r_byte_count == '0) || r_line_seen;
        end else begin
            row_start = (r_row_pos == '0);
        end
    end

    // Byte counter with row position and row count kept alongside
    always_comb begin
        n_byte_count = r_byte_count + 1'b1;
        n_row_pos    = r_row_pos;
        n_row_count  = r_row_count;
        if (&r_byte_count) begin
            // counter wraps to zero: row tracking restarts with it
            n_row_pos   = '0;
            n_row_count = '0;
        end else if (r_row_pos == ROW_LAST) begin
            n_row_pos   = '0;
            n_row_count = r_row_count + 1'b1;
        end else begin
            n_row_pos   = r_row_pos + 1'b1;
        end
    end

    // Saturating line counter
    always_comb begin
        n_line_count = r_line_count;
        if (line_event && !(&r_line_count)) begin
            n_line_count = r_line_count + 1'b1;
        end
    end

    // Limit check on the updated counts
    always_comb begin
        if (i_cfg.split_on_lines) begin
            limit_hit = CMP_W'(i_cfg.row_limit) < CMP_W'(n_line_count);
        end else begin
            limit_hit = CMP_W'(i_cfg.row_limit) <= CMP_W'(n_row_count);
        end
        n_stopped = r_stopped || ((i_cfg.row_limit != '0) && limit_hit);
    end

    // Result beat for the byte at the input
    always_comb begin
        offset_ext           = EXT_W'(r_byte_count);
        line_ext             = EXT_W'(n_line_count);
        o_result.byte_out    = i_byte;
        o_result.row_start   = row_start;
        o_result.row_offset  = offset_ext[lec_pkg::OUT_W-1:0];
        o_result.line_total  = line_ext[lec_pkg::OUT_W-1:0];
        o_result.ending_kind = n_ending;
        o_result.stop        = n_stopped;
    end

    // State update on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cr_pending <= 1'b0;
            r_ending     <= lec_pkg::KIND_NONE;
            r_line_seen  <= 1'b0;
            r_byte_count <= '0;
            r_line_count <= COUNT_BITS'(1);
            r_row_count  <= '0;
            r_row_pos    <= '0;
            r_stopped    <= 1'b0;
        end else if (i_accept) begin
            r_cr_pending <= n_cr_pending;
            r_ending     <= n_ending;
            r_line_seen  <= line_event;
            r_byte_count <= n_byte_count;
            r_line_count <= n_line_count;
            r_row_count  <= n_row_count;
            r_row_pos    <= n_row_pos;
            r_stopped    <= n_stopped;
        end
    end

    // Stop is sticky
    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |=> r_stopped)
        else $error("stop flag dropped without reset");

    // Mixed class is never left
    a_mixed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ending == lec_pkg::KIND_MIXED) |=> (r_ending == lec_pkg::KIND_MIXED))
        else $error("mixed ending class left");

    // Line counter starts at one and saturates, so it is never zero
    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> (r_line_count != '0))
        else $error("line counter reached zero");

endmodule

`default_nettype wire

// ===== hw/rtl/line_ending_classifier.sv =====
// Top level: configuration registers, byte tracker and registered result stage.
// Output: a result beat appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless o_res stalls; the only storage between
//   the sides is the single result register, refilling in the cycle it drains.
// Reset (i_rst_n low, synchronous): config to zero, counters cleared, line count
//   to one, ending class to none, no result beat held.
`default_nettype none

module line_ending_classifier #(
    parameter int ROW_BYTES  = lec_pkg::ROW_BYTES_DEF,
    parameter int COUNT_BITS = lec_pkg::COUNT_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lec_byte_if.sink  i_byte,
    lec_cfg_if.sink   i_cfg,
    lec_res_if.source o_res
);

    lec_pkg::t_cfg    r_cfg;
    lec_pkg::t_result r_res;
    lec_pkg::t_result step_res;
    logic             r_valid;
    logic             in_accept;

    // Result register takes a new beat when empty or draining
    assign i_byte.ready = !r_valid || o_res.ready;
    assign in_accept    = i_byte.valid && i_byte.ready;

    // Configuration writes are always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                lec_pkg::REG_SPLIT_ON_LINES: r_cfg.split_on_lines <= i_cfg.data[0];
                lec_pkg::REG_ROW_LIMIT:      r_cfg.row_limit      <= i_cfg.data;
                default: ;
            endcase
        end
    end

    lec_track #(
        .ROW_BYTES  (ROW_BYTES),
        .COUNT_BITS (COUNT_BITS)
    ) u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_byte.data_byte),
        .i_cfg    (r_cfg),
        .o_result (step_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_accept) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_res <= step_res;
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.byte_out    = r_res.byte_out;
    assign o_res.row_start   = r_res.row_start;
    assign o_res.row_offset  = r_res.row_offset;
    assign o_res.line_total  = r_res.line_total;
    assign o_res.ending_kind = r_res.ending_kind;
    assign o_res.stop        = r_res.stop;

    // Every accepted byte leaves a beat in the result register
    a_beat_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_valid)
        else $error("accepted byte produced no result beat");

    // A stalled result beat stays put until taken
    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !o_res.ready) |=> (r_valid && $stable(r_res)))
        else $error("stalled result beat changed");

    // An empty result register never blocks the input
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid |-> i_byte.ready)
        else $error("input blocked with empty result register");

endmodule

`default_nettype wire
